// ===== rtl/core/cdcc_pkg.sv =====
// Package for the calendar day count converter: item types, sequencer
// states, calendar constants and month tables. No dependencies.
`default_nettype none

package cdcc_pkg;

    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned WDAY_W  = 3;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned YOFF_W  = 7;   // year offset from the epoch year, 0..119
    localparam int unsigned CUM_W   = 9;   // cumulative days within a year, 0..366

    localparam logic [YEAR_W-1:0]  FIRST_YEAR = 12'd1980;
    localparam logic [YEAR_W-1:0]  LAST_YEAR  = 12'd2099;
    localparam logic [YOFF_W-1:0]  YEAR_SPAN  = 7'd119;
    localparam logic [COUNT_W-1:0] MAX_COUNT  = 16'd43830;
    localparam logic [CUM_W-1:0]   YEAR_DAYS  = 9'd365;
    localparam logic [CUM_W-1:0]   LEAP_DAYS  = 9'd366;
    localparam logic [1:0]         LEAP_MASK  = 2'h3;
    localparam logic [WDAY_W-1:0]  WEEK_DAYS  = 3'd7;
    // Weekday of the day before the epoch (epoch itself is a Tuesday).
    localparam logic [WDAY_W-1:0]  WDAY_BASE  = 3'd1;

    typedef enum logic [0:0] {
        OP_DATE_TO_COUNT = 1'b0,
        OP_COUNT_TO_DATE = 1'b1
    } cdcc_op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DATE  = 2'd1,
        ST_BAD_COUNT = 2'd2
    } cdcc_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_YEAR,
        S_MONTH,
        S_DAY,
        S_WDAY,
        S_MOD,
        S_SUM_MONTH,
        S_SUM_DAY
    } cdcc_state_t;

    typedef struct packed {
        logic [0:0]         operation;
        logic [YEAR_W-1:0]  year_in;
        logic [MONTH_W-1:0] month_in;
        logic [DAY_W-1:0]   day_in;
        logic [COUNT_W-1:0] count_in;
    } cdcc_req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count_out;
        logic [YEAR_W-1:0]  year_out;
        logic [MONTH_W-1:0] month_out;
        logic [DAY_W-1:0]   day_out;
        logic [WDAY_W-1:0]  weekday;
        logic [STAT_W-1:0]  status;
    } cdcc_res_t;

    // Days before the first of month idx+1 (idx 0..12).
    function automatic logic [CUM_W-1:0] cum_days(input logic leap,
                                                  input logic [MONTH_W-1:0] idx);
        logic [CUM_W-1:0] d;
        begin
            case (idx)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = 9'd59;
                4'd3:    d = 9'd90;
                4'd4:    d = 9'd120;
                4'd5:    d = 9'd151;
                4'd6:    d = 9'd181;
                4'd7:    d = 9'd212;
                4'd8:    d = 9'd243;
                4'd9:    d = 9'd273;
                4'd10:   d = 9'd304;
                4'd11:   d = 9'd334;
                4'd12:   d = 9'd365;
                default: d = 9'd0;
            endcase
            if (leap && idx >= 4'd2 && idx <= 4'd12)
                d = d + 9'd1;
            return d;
        end
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] d;
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
                4'd2:    d = leap ? 5'd29 : 5'd28;
                default: d = 5'd0;
            endcase
            return d;
        end
    endfunction

    // Month length mod 7, used to advance the weekday across a month.
    function automatic logic [1:0] month_len_mod7(input logic leap,
                                                  input logic [MONTH_W-1:0] m);
        logic [1:0] r;
        begin
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 2'd3;
                4'd4, 4'd6, 4'd9, 4'd11:                    r = 2'd2;
                4'd2:    r = leap ? 2'd1 : 2'd0;
                default: r = 2'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [WDAY_W-1:0] wday_add(input logic [WDAY_W-1:0] wd,
                                                   input logic [1:0] inc);
        logic [WDAY_W:0] s;
        begin
            s = {1'b0, wd} + {2'b00, inc};
            if (s >= {1'b0, WEEK_DAYS})
                s = s - {1'b0, WEEK_DAYS};
            return s[WDAY_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/calendar_day_count_converter_unit.sv =====
// Calendar date <-> day count converter, top level.
// Depends on cdcc_pkg (types, states, calendar tables).
`default_nettype none

// Usage
//   A request item is taken at a rising edge with start high and busy low.
//   The request carries the operation and both operand sets; only the set
//   that the operation names is looked at.
//     operation 0: year/month/day -> day count (1 = 1980-01-01)
//     operation 1: day count -> year/month/day/weekday
//   The result item sits on 'result' for exactly one cycle with done high.
//   The receiver cannot stall; nothing is held back for it.
// Sequencing
//   One shared 17-bit add/subtract unit does the day-count arithmetic under
//   a small sequencer, one step per cycle. Operation 0 checks the date,
//   adds one year length per step up to the requested year, then adds the
//   days before the month and the day. Operation 1 checks the count, walks
//   years and months, forms the day, then reduces day plus weekday mod 7.
//   Out-of-range requests finish straight from the check step.
//   busy is high from the cycle after acceptance until done; a new item
//   may be started in the cycle where done is high.
// Reset
//   rst_n clears the sequencer to idle and drops done; no clearing pass.

module calendar_day_count_converter_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire cdcc_pkg::cdcc_req_t request,
    output logic                    busy,
    output logic                    done,
    output cdcc_pkg::cdcc_res_t     result
);
    import cdcc_pkg::*;

    cdcc_state_t state_reg, state_next;
    cdcc_req_t   req_reg, req_next;
    cdcc_res_t   res_reg, res_next;
    logic        done_reg, done_next;

    logic [COUNT_W-1:0] acc_reg, acc_next;     // running count / remainder
    logic [YOFF_W-1:0]  yoff_reg, yoff_next;   // years walked so far
    logic [YOFF_W-1:0]  target_reg, target_next;
    logic [MONTH_W-1:0] mon_reg, mon_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [WDAY_W-1:0]  wd_reg, wd_next;

    // shared arithmetic unit
    logic [COUNT_W-1:0] alu_a, alu_b;
    logic               alu_sub;
    logic [COUNT_W:0]   alu_y;
    logic               alu_borrow, alu_zero;

    logic               leap;
    logic [COUNT_W-1:0] year_len;
    logic               date_ok;
    logic [YEAR_W-1:0]  year_off_full;

    assign alu_y      = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                                : ({1'b0, alu_a} + {1'b0, alu_b});
    assign alu_borrow = alu_sub & alu_y[COUNT_W];
    assign alu_zero   = (alu_y[COUNT_W-1:0] == '0);

    // 1980 is a multiple of 4, so the offset's low bits give leap years
    assign leap     = ((yoff_reg[1:0] & LEAP_MASK) == 2'b00);
    assign year_len = {{(COUNT_W-CUM_W){1'b0}}, (leap ? LEAP_DAYS : YEAR_DAYS)};

    assign year_off_full = req_reg.year_in - FIRST_YEAR;

    always_comb
    begin
        date_ok = (req_reg.year_in >= FIRST_YEAR) && (req_reg.year_in <= LAST_YEAR)
               && (req_reg.month_in >= 4'd1) && (req_reg.month_in <= 4'd12)
               && (req_reg.day_in != '0)
               && (req_reg.day_in <= month_len((req_reg.year_in[1:0] & LEAP_MASK) == 2'b00,
                                               req_reg.month_in));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        res_reg    <= res_next;
        acc_reg    <= acc_next;
        yoff_reg   <= yoff_next;
        target_reg <= target_next;
        mon_reg    <= mon_next;
        day_reg    <= day_next;
        wd_reg     <= wd_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        yoff_next   = yoff_reg;
        target_next = target_reg;
        mon_next    = mon_reg;
        day_next    = day_reg;
        wd_next     = wd_reg;
        alu_a       = acc_reg;
        alu_b       = '0;
        alu_sub     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                yoff_next   = '0;
                mon_next    = 4'd1;
                wd_next     = WDAY_BASE;
                target_next = year_off_full[YOFF_W-1:0];
                res_next    = '0;
                if (req_reg.operation == OP_DATE_TO_COUNT)
                begin
                    acc_next = '0;
                    if (!date_ok)
                    begin
                        res_next.status = ST_BAD_DATE;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (year_off_full[YOFF_W-1:0] == '0)
                        state_next = S_SUM_MONTH;
                    else
                        state_next = S_YEAR;
                end
                else
                begin
                    acc_next = req_reg.count_in;
                    if (req_reg.count_in == '0 || req_reg.count_in > MAX_COUNT)
                    begin
                        res_next.status = ST_BAD_COUNT;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                        state_next = S_YEAR;
                end
            end

            S_YEAR:
            begin
                alu_b = year_len;
                if (req_reg.operation == OP_DATE_TO_COUNT)
                begin
                    acc_next  = alu_y[COUNT_W-1:0];
                    yoff_next = yoff_reg + 7'd1;
                    if (yoff_reg + 7'd1 == target_reg)
                        state_next = S_SUM_MONTH;
                end
                else
                begin
                    alu_sub = 1'b1;
                    if (!alu_borrow && !alu_zero && yoff_reg != YEAR_SPAN)
                    begin
                        acc_next  = alu_y[COUNT_W-1:0];
                        yoff_next = yoff_reg + 7'd1;
                        wd_next   = wday_add(wd_reg, leap ? 2'd2 : 2'd1);
                    end
                    else
                        state_next = S_MONTH;
                end
            end

            S_MONTH:
            begin
                alu_sub = 1'b1;
                alu_b   = {{(COUNT_W-CUM_W){1'b0}}, cum_days(leap, mon_reg)};
                if (alu_borrow || alu_zero || mon_reg == 4'd12)
                    state_next = S_DAY;
                else
                begin
                    mon_next = mon_reg + 4'd1;
                    wd_next  = wday_add(wd_reg, month_len_mod7(leap, mon_reg));
                end
            end

            S_DAY:
            begin
                alu_sub    = 1'b1;
                alu_b      = {{(COUNT_W-CUM_W){1'b0}}, cum_days(leap, mon_reg - 4'd1)};
                day_next   = alu_y[DAY_W-1:0];
                state_next = S_WDAY;
            end

            S_WDAY:
            begin
                alu_a      = {{(COUNT_W-DAY_W){1'b0}}, day_reg};
                alu_b      = {{(COUNT_W-WDAY_W){1'b0}}, wd_reg};
                acc_next   = alu_y[COUNT_W-1:0];
                state_next = S_MOD;
            end

            S_MOD:
            begin
                alu_sub = 1'b1;
                alu_b   = {{(COUNT_W-WDAY_W){1'b0}}, WEEK_DAYS};
                if (!alu_borrow)
                    acc_next = alu_y[COUNT_W-1:0];
                else
                begin
                    res_next           = '0;
                    res_next.year_out  = FIRST_YEAR + {{(YEAR_W-YOFF_W){1'b0}}, yoff_reg};
                    res_next.month_out = mon_reg;
                    res_next.day_out   = day_reg;
                    res_next.weekday   = acc_reg[WDAY_W-1:0];
                    res_next.status    = ST_OK;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            S_SUM_MONTH:
            begin
                alu_b = {{(COUNT_W-CUM_W){1'b0}}, cum_days(leap, req_reg.month_in - 4'd1)};
                acc_next   = alu_y[COUNT_W-1:0];
                state_next = S_SUM_DAY;
            end

            S_SUM_DAY:
            begin
                alu_b              = {{(COUNT_W-DAY_W){1'b0}}, req_reg.day_in};
                res_next           = '0;
                res_next.count_out = alu_y[COUNT_W-1:0];
                res_next.status    = ST_OK;
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // done only appears once the sequencer is back at idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    // an accepted item always moves the sequencer out of idle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    // month walk never runs past December
    a_month_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MONTH) |-> (mon_reg >= 4'd1 && mon_reg <= 4'd12))
        else $error("month walk out of range");

    // year walk never runs past the last supported year
    a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_YEAR) |-> (yoff_reg <= YEAR_SPAN))
        else $error("year walk out of range");

    // a good date result carries a real weekday and month or a nonzero count
    a_ok_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_OK) |->
            ((result.weekday != WEEK_DAYS && result.month_out >= 4'd1
              && result.month_out <= 4'd12) || result.count_out != '0))
        else $error("ok result with empty fields");

endmodule

`default_nettype wire
